### rtl/rfmd_pkg.sv
// Package for the remote frame motor command decoder: item types, codes,
// command bytes and the Modbus CRC-16 byte update. No dependencies.
package rfmd_pkg;

  localparam int unsigned FRAME_LEN   = 6;
  localparam int unsigned STORE_DEPTH = 4;   // bytes 0..3 carry data, 4..5 the crc
  localparam logic [2:0]  LAST_POS    = 3'(FRAME_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // command bytes
  localparam logic [7:0] CMD_FWD   = 8'h77;  // w
  localparam logic [7:0] CMD_BACK  = 8'h73;  // s
  localparam logic [7:0] CMD_LEFT  = 8'h61;  // a
  localparam logic [7:0] CMD_RIGHT = 8'h64;  // d
  localparam logic [7:0] CMD_STOP  = 8'h65;  // e
  localparam logic [7:0] BUZZ_ON   = 8'hFF;
  localparam logic [7:0] BUZZ_OFF  = 8'h00;

  // low motor patterns
  localparam logic [3:0] DRV_FWD   = 4'h5;
  localparam logic [3:0] DRV_BACK  = 4'hA;
  localparam logic [3:0] DRV_LEFT  = 4'h9;
  localparam logic [3:0] DRV_RIGHT = 4'h6;
  localparam logic [3:0] DRV_STOP  = 4'h0;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] CFG_NODE_ADDR = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd1;

  localparam logic [7:0] TIMEOUT_RESET = 8'd4;

  typedef enum logic [1:0] {
    FS_NONE    = 2'd0,
    FS_OK      = 2'd1,
    FS_CRC_ERR = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0] motor_drive;
    logic [1:0] switch_drive;
    logic       buzzer_drive;
    logic [1:0] frame_status;
    logic       timed_out;
  } out_item_t;

  // frame event from the assembler to the drive control
  typedef struct packed {
    logic       done;
    logic       crc_ok;
    logic [7:0] cmd;
    logic [7:0] bits;
    logic [7:0] buzz;
  } frame_evt_t;

  // one byte of reflected crc-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

### rtl/rfmd_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Uses no package; the payload type is given at instantiation.
interface rfmd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rfmd_frame_asm.sv
// Frame assembler: byte position, stored data bytes and running crc.
// Depends on rfmd_pkg.
module rfmd_frame_asm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [3:0]          node_addr,
  output rfmd_pkg::frame_evt_t evt
);
  import rfmd_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  store_r [STORE_DEPTH];
  logic [7:0]  first_byte;
  logic [2:0]  pos_inc;

  // next position and crc for this byte
  always_comb begin
    first_byte = (pos_r == 3'd0) ? rx_byte : store_r[0];
    crc_nxt    = crc_byte((pos_r == 3'd0) ? CRC_INIT : crc_r, rx_byte);
    pos_inc    = pos_r + 3'd1;
    if (first_byte != {4'h0, node_addr}) pos_inc = 3'd0;
    evt.done   = (pos_inc == LAST_POS);
    pos_nxt    = evt.done ? 3'd0 : pos_inc;
    evt.crc_ok = (crc_nxt == 16'h0000);
    evt.cmd    = store_r[1];
    evt.bits   = store_r[2];
    evt.buzz   = store_r[3];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
      crc_r <= CRC_INIT;
    end else if (step) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // data bytes; crc bytes are not kept
  always_ff @(posedge clk) begin
    if (step && (pos_r < 3'(STORE_DEPTH))) begin
      store_r[pos_r[1:0]] <= rx_byte;
    end
  end
endmodule

### rtl/rfmd_drive_ctl.sv
// Drive control: tick counter, timeout and output levels from decoded frames.
// Depends on rfmd_pkg.
module rfmd_drive_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 op,
  input  rfmd_pkg::frame_evt_t evt,
  input  logic [7:0]           timeout_ticks,
  output rfmd_pkg::out_item_t  res
);
  import rfmd_pkg::*;

  logic [7:0] tick_r, tick_nxt;
  logic [5:0] motor_r, motor_nxt;
  logic [1:0] switch_r, switch_nxt;
  logic       buzz_r, buzz_nxt;
  logic       fired;
  logic [1:0] status;
  logic [3:0] low;
  logic [1:0] m3;

  // next levels for one item
  always_comb begin
    tick_nxt   = tick_r;
    motor_nxt  = motor_r;
    switch_nxt = switch_r;
    buzz_nxt   = buzz_r;
    fired      = 1'b0;
    status     = FS_NONE;
    low        = motor_r[3:0];
    m3         = 2'b00;

    // drive command decode
    case (evt.cmd)
      CMD_FWD:   low = DRV_FWD;
      CMD_BACK:  low = DRV_BACK;
      CMD_LEFT:  low = DRV_LEFT;
      CMD_RIGHT: low = DRV_RIGHT;
      CMD_STOP:  low = DRV_STOP;
      default:   low = motor_r[3:0];
    endcase
    if (evt.bits[1])      m3 = 2'b01;
    else if (evt.bits[2]) m3 = 2'b10;

    if (op == OP_TICK) begin
      if (tick_r != 8'hFF) begin
        tick_nxt = tick_r + 8'd1;
        if (tick_nxt == timeout_ticks) begin
          motor_nxt = 6'd0;
          buzz_nxt  = 1'b0;
          fired     = 1'b1;
        end
      end
    end else if (evt.done) begin
      if (evt.crc_ok) begin
        status     = FS_OK;
        tick_nxt   = 8'd0;
        motor_nxt  = {m3, low};
        switch_nxt = {evt.bits[3], evt.bits[0]};
        if (evt.buzz == BUZZ_ON)       buzz_nxt = 1'b1;
        else if (evt.buzz == BUZZ_OFF) buzz_nxt = 1'b0;
      end else begin
        status = FS_CRC_ERR;
      end
    end

    res.motor_drive  = motor_nxt;
    res.switch_drive = switch_nxt;
    res.buzzer_drive = buzz_nxt;
    res.frame_status = status;
    res.timed_out    = fired;
  end

  // level and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= 8'd0;
      motor_r  <= 6'd0;
      switch_r <= 2'd0;
      buzz_r   <= 1'b0;
    end else if (step) begin
      tick_r   <= tick_nxt;
      motor_r  <= motor_nxt;
      switch_r <= switch_nxt;
      buzz_r   <= buzz_nxt;
    end
  end
endmodule

### rtl/remote_frame_motor_command_decoder.sv
// Top level of the remote frame motor command decoder: input and result
// registers, configuration registers. Depends on rfmd_pkg, rfmd_stream_if,
// rfmd_frame_asm and rfmd_drive_ctl.
//
//   channel  direction  carries
//   in_ch    sink       op, rx_byte (byte or timer tick)
//   out_ch   source     motor, switch, buzzer levels, frame status, timeout
//   cfg_*    write      index 0 node address, index 1 timeout ticks
//
// One request per clock while the result register is not stalled: an item
// is held in the input register, is processed by the crc byte update and
// decode logic and lands in the result register.
// A stalled result register holds the input register; in_ch.ready stays high
// while the input register is empty or moving on. Synchronous reset clears
// the control state; node address resets to 0, timeout ticks to 4.
module remote_frame_motor_command_decoder (
  input  logic       clk,
  input  logic       rst_n,
  rfmd_stream_if.sink   in_ch,
  rfmd_stream_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata
);
  import rfmd_pkg::*;

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  logic [3:0] node_addr_r;
  logic [7:0] timeout_r;
  logic       advance;
  logic       step;
  frame_evt_t evt;
  out_item_t  res;

  // pipeline flow
  assign advance      = !out_vld_r || out_ch.ready;
  assign step         = in_vld_r && advance;
  assign in_ch.ready  = !in_vld_r || advance;
  assign out_ch.valid = out_vld_r;
  assign out_ch.payload = out_item_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.payload;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 4'd0;
      timeout_r   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NODE_ADDR: node_addr_r <= cfg_wdata[3:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  rfmd_frame_asm u_frame_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step && (in_item_r.op == OP_BYTE)),
    .rx_byte   (in_item_r.rx_byte),
    .node_addr (node_addr_r),
    .evt       (evt)
  );

  rfmd_drive_ctl u_drive_ctl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .op            (in_item_r.op),
    .evt           (evt),
    .timeout_ticks (timeout_r),
    .res           (res)
  );
endmodule
